/* hw/rtl/edpf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the edge depth deprojection filter.
// No dependencies; imported by edpf_front, edpf_lane and the top level.
package edpf_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);

  typedef enum logic [RegIdxW-1:0] {
    REG_ROW_WINDOW   = 3'd0,
    REG_DEPTH_WINDOW = 3'd1,
    REG_CENTER_COL   = 3'd2,
    REG_CENTER_ROW   = 3'd3,
    REG_INV_FOCAL_X  = 3'd4,
    REG_INV_FOCAL_Y  = 3'd5,
    REG_MIN_HEIGHT   = 3'd6,
    REG_MAX_HEIGHT   = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] RowWindowRst   = 32'd47185920;
  localparam logic [31:0] DepthWindowRst = 32'd655360000;
  localparam logic [31:0] MinHeightRst   = 32'hFFFF_F830;
  localparam logic [31:0] MaxHeightRst   = 32'd2000;

  typedef struct packed {
    logic [31:0]        row_window;
    logic [31:0]        depth_window;
    logic [15:0]        center_col;
    logic [15:0]        center_row;
    logic [31:0]        inv_focal_x;
    logic [31:0]        inv_focal_y;
    logic signed [31:0] height_lo;
    logic signed [31:0] height_hi;
  } cfg_t;

  // Pixel offset from the principal point, Q12.4 sign and magnitude.
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } offset_t;

  typedef struct packed {
    logic [15:0] depth;
    offset_t     row_off;
    offset_t     col_off;
  } stage1_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

/* hw/rtl/edpf_front.sv */
`timescale 1ns / 1ps
// Stage 1: edge, row and depth window filter plus principal point offsets.
// Depends on edpf_pkg.
module edpf_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  edpf_pkg::cfg_t   cfg_i,
  input  logic             edge_flag_i,
  input  logic [15:0]      depth_mm_i,
  input  logic [11:0]      pixel_row_i,
  input  logic [11:0]      pixel_col_i,
  output logic             keep_o,
  output edpf_pkg::stage1_t s1_o
);
  import edpf_pkg::*;

  stage1_t     s1_d;
  stage1_t     s1_q;
  logic [15:0] row_ext;

  function automatic offset_t pix_offset(logic [11:0] pix, logic [15:0] ctr);
    offset_t     off;
    logic [15:0] p16;
    begin
      p16 = {pix, 4'b0000};
      off.neg = (p16 < ctr);
      off.mag = off.neg ? (ctr - p16) : (p16 - ctr);
      return off;
    end
  endfunction

  assign row_ext = {4'b0000, pixel_row_i};

  assign keep_o = edge_flag_i
               && (row_ext >= cfg_i.row_window[15:0])
               && (row_ext <  cfg_i.row_window[31:16])
               && (depth_mm_i >= cfg_i.depth_window[15:0])
               && (depth_mm_i <= cfg_i.depth_window[31:16]);

  always_comb begin
    s1_d.depth   = depth_mm_i;
    s1_d.row_off = pix_offset(pixel_row_i, cfg_i.center_row);
    s1_d.col_off = pix_offset(pixel_col_i, cfg_i.center_col);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

/* hw/rtl/edpf_lane.sv */
`timescale 1ns / 1ps
// Stages 2 to 4 of one axis: offset times depth, times focal reciprocal,
// then round half away from zero and negate. Depends on edpf_pkg.
module edpf_lane (
  input  logic                clk_i,
  input  edpf_pkg::pipe_en_t  en_i,
  input  edpf_pkg::offset_t   off_i,
  input  logic [15:0]         depth_i,
  input  logic [31:0]         inv_focal_i,
  output logic signed [31:0]  coord_o
);
  import edpf_pkg::*;

  logic [31:0]        prod1_q;
  logic               neg2_q;
  logic [63:0]        prod2;
  logic [28:0]        hi_q;
  logic               neg3_q;
  logic [28:0]        rnd;
  logic [31:0]        mag32;
  logic signed [31:0] coord_d;
  logic signed [31:0] coord_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod1_q <= 32'(off_i.mag) * 32'(depth_i);
      neg2_q  <= off_i.neg;
    end
  end

  assign prod2 = 64'(prod1_q) * 64'(inv_focal_i);

  // Keep the integer part and the first fraction bit.
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      hi_q   <= prod2[63:35];
      neg3_q <= neg2_q;
    end
  end

  // Magnitude stays below 2^28 + 1, so the 32-bit result never saturates.
  assign rnd     = {1'b0, hi_q[28:1]} + {28'd0, hi_q[0]};
  assign mag32   = {3'b000, rnd};
  assign coord_d = neg3_q ? $signed(mag32) : $signed(~mag32 + 32'd1);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

/* hw/rtl/edge_depth_deprojection_filter_top.sv */
`timescale 1ns / 1ps
// Top level of the edge depth deprojection filter: config registers,
// pipeline control, height check and output register.
// Depends on edpf_pkg, edpf_front, edpf_lane.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | in_valid_i / in_stall_o  | edge_flag_i depth_mm_i pixel_row_i/col_i
//   out     | out_valid_o / out_stall_i| forward_mm_o lateral_mm_o vertical_mm_o
//   cfg     | cfg_we_i                 | cfg_idx_i cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low.
// Cycle time is set by the 32x32 reciprocal multiply in stage 3.
// Asynchronous active-low reset clears valid bits and loads config reset values.
// Each stage advances when empty or when the stage after it advances, so
// bubbles close up under a stall; in_stall_o rises only with all stages full.
module edge_depth_deprojection_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [edpf_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          edge_flag_i,
  input  logic [15:0]                   depth_mm_i,
  input  logic [11:0]                   pixel_row_i,
  input  logic [11:0]                   pixel_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   forward_mm_o,
  output logic signed [31:0]            lateral_mm_o,
  output logic signed [31:0]            vertical_mm_o
);
  import edpf_pkg::*;

  cfg_t               cfg_q;
  pipe_en_t           en;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic               keep1;
  stage1_t            s1;
  logic [15:0]        depth2_q, depth3_q, depth4_q;
  logic signed [31:0] lat4, vert4;
  logic               height_ok;
  logic [15:0]        fwd_q;
  logic signed [31:0] lat_q, vert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_window   <= RowWindowRst;
      cfg_q.depth_window <= DepthWindowRst;
      cfg_q.center_col   <= '0;
      cfg_q.center_row   <= '0;
      cfg_q.inv_focal_x  <= '0;
      cfg_q.inv_focal_y  <= '0;
      cfg_q.height_lo    <= $signed(MinHeightRst);
      cfg_q.height_hi    <= $signed(MaxHeightRst);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_WINDOW:   cfg_q.row_window   <= cfg_data_i;
        REG_DEPTH_WINDOW: cfg_q.depth_window <= cfg_data_i;
        REG_CENTER_COL:   cfg_q.center_col   <= cfg_data_i[15:0];
        REG_CENTER_ROW:   cfg_q.center_row   <= cfg_data_i[15:0];
        REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_data_i;
        REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_data_i;
        REG_MIN_HEIGHT:   cfg_q.height_lo    <= $signed(cfg_data_i);
        REG_MAX_HEIGHT:   cfg_q.height_hi    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en.s5 = !v5_q || !out_stall_i;
    en.s4 = !v4_q || en.s5;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_stall_o = !en.s1;

  assign height_ok = (vert4 >= $signed(cfg_q.height_lo))
                  && (vert4 <= $signed(cfg_q.height_hi));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i && keep1;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
      if (en.s5) v5_q <= v4_q && height_ok;
    end
  end

  edpf_front u_front (
    .clk_i       (clk_i),
    .en_i        (en.s1),
    .cfg_i       (cfg_q),
    .edge_flag_i (edge_flag_i),
    .depth_mm_i  (depth_mm_i),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .keep_o      (keep1),
    .s1_o        (s1)
  );

  edpf_lane u_lane_vert (
    .clk_i       (clk_i),
    .en_i        (en),
    .off_i       (s1.row_off),
    .depth_i     (s1.depth),
    .inv_focal_i (cfg_q.inv_focal_y),
    .coord_o     (vert4)
  );

  edpf_lane u_lane_lat (
    .clk_i       (clk_i),
    .en_i        (en),
    .off_i       (s1.col_off),
    .depth_i     (s1.depth),
    .inv_focal_i (cfg_q.inv_focal_x),
    .coord_o     (lat4)
  );

  always_ff @(posedge clk_i) begin
    if (en.s2) depth2_q <= s1.depth;
    if (en.s3) depth3_q <= depth2_q;
    if (en.s4) depth4_q <= depth3_q;
    if (en.s5) begin
      fwd_q  <= depth4_q;
      lat_q  <= lat4;
      vert_q <= vert4;
    end
  end

  assign out_valid_o   = v5_q;
  assign forward_mm_o  = fwd_q;
  assign lateral_mm_o  = lat_q;
  assign vertical_mm_o = vert_q;

endmodule

/* hw/rtl/edpf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the edge depth deprojection filter, bound to the top.
// Depends on edge_depth_deprojection_filter_top.
module edpf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [15:0]                   forward_mm_o,
  input logic signed [31:0]            lateral_mm_o,
  input logic signed [31:0]            vertical_mm_o
);

  localparam logic signed [31:0] CoordMax = 32'sd268435456;
  localparam logic signed [31:0] CoordMin = -32'sd268435456;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(forward_mm_o) && $stable(lateral_mm_o) && $stable(vertical_mm_o))
    else $error("stalled output payload changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is free");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lateral_mm_o <= CoordMax) && (lateral_mm_o >= CoordMin)
                 && (vertical_mm_o <= CoordMax) && (vertical_mm_o >= CoordMin))
    else $error("coordinate outside reachable range");

endmodule

bind edge_depth_deprojection_filter_top edpf_checker u_edpf_checker (.*);
